>>> design/bba_pkg.sv
// shared constants and types of the buddy block allocator
`default_nettype none

package bba_pkg;

    // region geometry
    localparam int REGION_ORDER = 12;
    localparam int MIN_ORDER    = 3;
    localparam int HEADER_BYTES = 4;

    // field widths
    localparam int ADDR_W  = 12;
    localparam int ORD_W   = 4;
    localparam int BYTES_W = 16;
    localparam int STAT_W  = 2;
    localparam int NEED_W  = BYTES_W + 1;

    // tag store: one entry per minimum-size slot
    localparam int SLOT_W     = REGION_ORDER - MIN_ORDER;
    localparam int SLOT_COUNT = 1 << SLOT_W;

    // free bitmap: node index 1 .. 2*SLOT_COUNT-1, packed into words
    localparam int NODE_W    = SLOT_W + 1;
    localparam int BIT_W     = 5;
    localparam int WORD_BITS = 1 << BIT_W;
    localparam int FM_AW     = NODE_W - BIT_W;
    localparam int FM_WORDS  = 1 << FM_AW;

    // request command codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_TAKE,
        OP_SPLIT_RD,
        OP_SPLIT_WR,
        OP_TAG_WR,
        OP_TAG_RD,
        OP_TAG_CLR,
        OP_BUD_RD,
        OP_BUD_CLR,
        OP_TOP_RD,
        OP_TOP_WR,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic too_large;
        logic misaligned;
        logic hit;
        logic last_word;
        logic k_top;
        logic split_done;
        logic tag_bad;
        logic bud_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/bba_req_if.sv
// request channel: command, byte count and block address
`default_nettype none

interface bba_req_if;
    import bba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [BYTES_W-1:0]   byte_count;
    logic [ADDR_W-1:0]    block_address;

    modport source (output valid, command, byte_count, block_address, input ready);
    modport sink   (input valid, command, byte_count, block_address, output ready);
endinterface

`default_nettype wire

>>> design/bba_rsp_if.sv
// response channel: status, granted address and order
`default_nettype none

interface bba_rsp_if;
    import bba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [ADDR_W-1:0]    granted_address;
    logic [ORD_W-1:0]     granted_order;

    modport source (output valid, status, granted_address, granted_order, input ready);
    modport sink   (input valid, status, granted_address, granted_order, output ready);
endinterface

`default_nettype wire

>>> design/bba_dp.sv
// allocator datapath: free bitmap, tag store, address and order registers
`default_nettype none

module bba_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          command,
    input  logic [bba_pkg::BYTES_W-1:0]   byte_count,
    input  logic [bba_pkg::ADDR_W-1:0]    block_address,
    input  bba_pkg::dp_cmd_t              cmd,
    output bba_pkg::dp_sts_t              sts,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic [bba_pkg::ADDR_W-1:0]    granted_address,
    output logic [bba_pkg::ORD_W-1:0]     granted_order
);
    import bba_pkg::*;

    localparam logic [NODE_W-1:0] TOP_NODE = NODE_W'(1);

    // node index of the block of order k at addr
    function automatic logic [NODE_W-1:0] node_of(logic [ORD_W-1:0] k,
                                                  logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] t;
        t = {1'b1, addr} >> k;
        return t[NODE_W-1:0];
    endfunction

    // memories
    logic [WORD_BITS-1:0] fm_mem [FM_WORDS];
    logic [ORD_W-1:0]     tag_mem [SLOT_COUNT];

    // registers
    logic [WORD_BITS-1:0] fm_rd_reg;
    logic [ORD_W-1:0]     tag_rd_reg;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic                 is_free_reg;
    logic                 too_large_reg;
    logic [ORD_W-1:0]     need_ord_reg;
    logic [ORD_W-1:0]     k_reg;
    logic [ADDR_W-1:0]    a_reg;
    logic [FM_AW-1:0]     widx_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [ADDR_W-1:0]    gaddr_reg;
    logic [ORD_W-1:0]     gord_reg;

    // combinational
    logic [NEED_W-1:0]    need;
    logic [NEED_W-1:0]    need_m1;
    logic [ORD_W-1:0]     need_ord;
    logic [ORD_W-1:0]     lvl;
    logic [FM_AW-1:0]     base;
    logic [FM_AW-1:0]     scan_word;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] masked;
    logic [BIT_W-1:0]     pos;
    logic [NODE_W-1:0]    found_node;
    logic [NODE_W+ADDR_W-1:0] found_sh;
    logic [ADDR_W:0]      bit_k_w;
    logic [ADDR_W:0]      half_w;
    logic [ADDR_W:0]      tag_span_w;
    logic [ADDR_W-1:0]    tag_mask;
    logic [NODE_W-1:0]    split_node;
    logic [NODE_W-1:0]    bud_node;
    logic [NODE_W-1:0]    top_node;
    logic                 last_word;
    logic                 fm_we;
    logic [FM_AW-1:0]     fm_waddr;
    logic [FM_AW-1:0]     fm_raddr;
    logic [WORD_BITS-1:0] fm_wdata;
    logic                 tag_we;
    logic [SLOT_W-1:0]    tag_waddr;
    logic [ORD_W-1:0]     tag_wdata;

    // size class of the request
    always_comb
    begin
        need     = NEED_W'(byte_count) + NEED_W'(HEADER_BYTES);
        need_m1  = need - NEED_W'(1);
        need_ord = ORD_W'(MIN_ORDER);
        for (int i = MIN_ORDER; i < REGION_ORDER; i++)
        begin
            if (need_m1[i] && need != '0)
                need_ord = ORD_W'(i + 1);
        end
    end

    // word range and mask of the order under scan
    always_comb
    begin
        lvl  = ORD_W'(REGION_ORDER) - k_reg;
        base = FM_AW'(1) << (lvl - ORD_W'(BIT_W));
        if (lvl < ORD_W'(BIT_W))
        begin
            scan_word = '0;
            last_word = 1'b1;
            for (int b = 0; b < WORD_BITS; b++)
                scan_mask[b] = (b >= (1 << lvl)) && (b < (2 << lvl));
        end
        else
        begin
            scan_word = base + widx_reg;
            last_word = (widx_reg == base - FM_AW'(1));
            scan_mask = '1;
        end
    end

    // lowest free node in the word just read
    always_comb
    begin
        masked = fm_rd_reg & scan_mask;
        pos    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (masked[b])
                pos = BIT_W'(b);
        end
        found_node = {scan_word, pos};
        found_sh   = {{ADDR_W{1'b0}}, found_node} << k_reg;
    end

    // node addresses for split, buddy and final free
    always_comb
    begin
        bit_k_w    = (ADDR_W+1)'(1) << k_reg;
        half_w     = (ADDR_W+1)'(1) << (k_reg - ORD_W'(1));
        tag_span_w = ((ADDR_W+1)'(1) << tag_rd_reg) - (ADDR_W+1)'(1);
        tag_mask   = tag_span_w[ADDR_W-1:0];
        split_node = node_of(k_reg - ORD_W'(1), a_reg | half_w[ADDR_W-1:0]);
        bud_node   = node_of(k_reg, a_reg ^ bit_k_w[ADDR_W-1:0]);
        top_node   = node_of(k_reg, a_reg);
    end

    // bitmap port control
    always_comb
    begin
        fm_we    = 1'b0;
        fm_waddr = '0;
        fm_wdata = fm_rd_reg;
        fm_raddr = scan_word;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                fm_we    = (clr_cnt_reg < SLOT_W'(FM_WORDS));
                fm_waddr = clr_cnt_reg[FM_AW-1:0];
                fm_wdata = (clr_cnt_reg == '0) ?
                           (WORD_BITS'(1) << TOP_NODE[BIT_W-1:0]) : '0;
            end
            OP_TAKE:
            begin
                fm_we    = 1'b1;
                fm_waddr = scan_word;
                fm_wdata = fm_rd_reg & ~(WORD_BITS'(1) << pos);
            end
            OP_SPLIT_RD: fm_raddr = split_node[NODE_W-1:BIT_W];
            OP_SPLIT_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = split_node[NODE_W-1:BIT_W];
                fm_wdata = fm_rd_reg | (WORD_BITS'(1) << split_node[BIT_W-1:0]);
            end
            OP_BUD_RD: fm_raddr = bud_node[NODE_W-1:BIT_W];
            OP_BUD_CLR:
            begin
                fm_we    = 1'b1;
                fm_waddr = bud_node[NODE_W-1:BIT_W];
                fm_wdata = fm_rd_reg & ~(WORD_BITS'(1) << bud_node[BIT_W-1:0]);
            end
            OP_TOP_RD: fm_raddr = top_node[NODE_W-1:BIT_W];
            OP_TOP_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = top_node[NODE_W-1:BIT_W];
                fm_wdata = fm_rd_reg | (WORD_BITS'(1) << top_node[BIT_W-1:0]);
            end
            default: ;
        endcase
    end

    // tag port control
    always_comb
    begin
        tag_we    = 1'b0;
        tag_waddr = a_reg[ADDR_W-1:MIN_ORDER];
        tag_wdata = '0;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_cnt_reg;
            end
            OP_TAG_WR:
            begin
                tag_we    = 1'b1;
                tag_wdata = need_ord_reg;
            end
            OP_TAG_CLR: tag_we = 1'b1;
            default: ;
        endcase
    end

    // memories with registered read
    always_ff @(posedge clk)
    begin
        if (fm_we)
            fm_mem[fm_waddr] <= fm_wdata;
        fm_rd_reg <= fm_mem[fm_raddr];
        if (tag_we)
            tag_mem[tag_waddr] <= tag_wdata;
        tag_rd_reg <= tag_mem[a_reg[ADDR_W-1:MIN_ORDER]];
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.op == OP_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                is_free_reg   <= command;
                too_large_reg <= (need > NEED_W'(1 << REGION_ORDER));
                need_ord_reg  <= need_ord;
                k_reg         <= need_ord;
                widx_reg      <= '0;
                a_reg         <= block_address;
            end
            OP_SCAN_NEXT:
            begin
                if (last_word)
                begin
                    k_reg    <= k_reg + ORD_W'(1);
                    widx_reg <= '0;
                end
                else
                    widx_reg <= widx_reg + FM_AW'(1);
            end
            OP_TAKE:     a_reg <= found_sh[ADDR_W-1:0];
            OP_SPLIT_WR: k_reg <= k_reg - ORD_W'(1);
            OP_TAG_CLR:
            begin
                k_reg <= tag_rd_reg;
                a_reg <= a_reg & ~tag_mask;
            end
            OP_BUD_CLR:
            begin
                a_reg <= a_reg & ~bit_k_w[ADDR_W-1:0];
                k_reg <= k_reg + ORD_W'(1);
            end
            OP_RESULT:
            begin
                status_reg <= cmd.res;
                if (cmd.res == ST_OK && is_free_reg == REQ_ALLOC)
                begin
                    gaddr_reg <= a_reg;
                    gord_reg  <= need_ord_reg;
                end
                else
                begin
                    gaddr_reg <= '0;
                    gord_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb
    begin
        sts.clr_done   = &clr_cnt_reg;
        sts.is_free    = (is_free_reg == REQ_FREE);
        sts.too_large  = too_large_reg;
        sts.misaligned = |a_reg[MIN_ORDER-1:0];
        sts.hit        = |masked;
        sts.last_word  = last_word;
        sts.k_top      = (k_reg == ORD_W'(REGION_ORDER));
        sts.split_done = (k_reg == need_ord_reg);
        sts.tag_bad    = (tag_rd_reg < ORD_W'(MIN_ORDER)) ||
                         (tag_rd_reg > ORD_W'(REGION_ORDER));
        sts.bud_free   = fm_rd_reg[bud_node[BIT_W-1:0]];
    end

    assign status          = status_reg;
    assign granted_address = gaddr_reg;
    assign granted_order   = gord_reg;

endmodule

`default_nettype wire

>>> design/bba_ctrl.sv
// allocator controller: sequences search, split, merge and result transfer
`default_nettype none

module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bba_pkg::dp_cmd_t  cmd,
    input  bba_pkg::dp_sts_t  sts
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_SPLIT_WR,
        S_TAG_RD,
        S_TAG_CHK,
        S_MERGE,
        S_BUD_CHK,
        S_TOP_WR,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;

    // next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        cmd.op         = OP_NONE;
        cmd.res        = res_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (sts.is_free && sts.misaligned)
                begin
                    res_next   = ST_BAD_FREE;
                    state_next = S_RESULT;
                end
                else if (sts.is_free)
                    state_next = S_TAG_RD;
                else if (sts.too_large)
                begin
                    res_next   = ST_TOO_LARGE;
                    state_next = S_RESULT;
                end
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                priority if (sts.hit)
                begin
                    cmd.op     = OP_TAKE;
                    state_next = S_SPLIT;
                end
                else if (sts.last_word && sts.k_top)
                begin
                    res_next   = ST_NO_FREE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_SPLIT:
            begin
                if (sts.split_done)
                begin
                    cmd.op     = OP_TAG_WR;
                    res_next   = ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_SPLIT_RD;
                    state_next = S_SPLIT_WR;
                end
            end
            S_SPLIT_WR:
            begin
                cmd.op     = OP_SPLIT_WR;
                state_next = S_SPLIT;
            end
            S_TAG_RD:
            begin
                cmd.op     = OP_TAG_RD;
                state_next = S_TAG_CHK;
            end
            S_TAG_CHK:
            begin
                if (sts.tag_bad)
                begin
                    res_next   = ST_BAD_FREE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_TAG_CLR;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (sts.k_top)
                begin
                    cmd.op     = OP_TOP_RD;
                    state_next = S_TOP_WR;
                end
                else
                begin
                    cmd.op     = OP_BUD_RD;
                    state_next = S_BUD_CHK;
                end
            end
            S_BUD_CHK:
            begin
                if (sts.bud_free)
                begin
                    cmd.op     = OP_BUD_CLR;
                    state_next = S_MERGE;
                end
                else
                begin
                    cmd.op     = OP_TOP_RD;
                    state_next = S_TOP_WR;
                end
            end
            S_TOP_WR:
            begin
                cmd.op     = OP_TOP_WR;
                res_next   = ST_OK;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request taken during clearing pass");

    a_take_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_TAKE) |-> sts.hit)
        else $error("block taken without a free bit");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |=> out_valid_reg)
        else $error("result not presented");

    a_split_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SPLIT_RD) |-> !sts.split_done)
        else $error("split below requested order");

endmodule

`default_nettype wire

>>> design/buddy_block_allocator.sv
// Buddy block allocator over a 4096-byte region, block orders 3 to 12. After
// reset a clearing pass sweeps the tag store (and the 32-word free bitmap)
// before the first request is taken. Requests are handled one at a time by a
// controller stepping a datapath that owns a 32 x 32-bit free bitmap memory
// and a 512 x 4-bit tag memory, each with one registered read port, so every
// bitmap or tag access is split into a read step and a check/write step. An
// allocate scans the bitmap words from the requested order upward and then
// splits the found block down to the requested order; a free merges the block
// with each free buddy, at most up to the whole region. Too large and
// misaligned requests are rejected before any memory access, a free of an
// unallocated address after its tag read. The next request can be taken from
// the cycle in which the result shows. A finished result sits in an output
// register while the next request is taken; a new result waits until the
// previous one has been transferred.
`default_nettype none

module buddy_block_allocator (
    input  logic       clk,
    input  logic       rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);
    import bba_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // storage and arithmetic
    bba_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (req.command),
        .byte_count      (req.byte_count),
        .block_address   (req.block_address),
        .cmd             (cmd),
        .sts             (sts),
        .status          (rsp.status),
        .granted_address (rsp.granted_address),
        .granted_order   (rsp.granted_order)
    );

endmodule

`default_nettype wire

>>> dv/buddy_block_allocator_tb.sv
// self-checking testbench of the buddy block allocator
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
    import bba_pkg::*;

    typedef struct packed {
        status_t          status;
        logic [ADDR_W-1:0] addr;
        logic [ORD_W-1:0]  order;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #5 clk = ~clk;

    // predictor state
    logic       free_bit [1:2*SLOT_COUNT-1];
    logic [3:0] tag_order [0:SLOT_COUNT-1];
    grant_t     grant_queue[$];
    int         errors = 0;
    int         hold_cycles = 0;
    int         stall_mode = 0;
    logic [ADDR_W-1:0] live_blocks[$];

    function automatic int node_of(int order, int addr);
        return (1 << (REGION_ORDER - order)) + (addr >> order);
    endfunction

    function automatic void reset_allocator();
        for (int i = 1; i < 2*SLOT_COUNT; i++) free_bit[i] = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) tag_order[i] = '0;
        free_bit[1] = 1'b1;
    endfunction

    // compute the grant of one request and update the predicted state
    function automatic grant_t predict_grant(logic cmd, logic [15:0] bytes,
                                             logic [11:0] baddr);
        grant_t g;
        int need, order, k, a, n;
        bit found;
        g = '{ST_OK, '0, '0};
        if (cmd == REQ_ALLOC) begin
            need = int'(bytes) + HEADER_BYTES;
            if (need > (1 << REGION_ORDER)) begin
                g.status = ST_TOO_LARGE;
                return g;
            end
            order = MIN_ORDER;
            while (order < REGION_ORDER && (1 << order) < need) order++;
            found = 0;
            a = 0;
            for (k = order; k <= REGION_ORDER; k++) begin
                n = 1 << (REGION_ORDER - k);
                for (int j = 0; j < n; j++)
                    if (!found && free_bit[n + j]) begin
                        a = j << k;
                        found = 1;
                    end
                if (found) break;
            end
            if (!found) begin
                g.status = ST_NO_FREE;
                return g;
            end
            free_bit[node_of(k, a)] = 1'b0;
            for (int j = k; j > order; j--)
                free_bit[node_of(j - 1, a + (1 << (j - 1)))] = 1'b1;
            tag_order[a >> MIN_ORDER] = ORD_W'(order);
            g.addr = ADDR_W'(a);
            g.order = ORD_W'(order);
        end else begin
            if (baddr[MIN_ORDER-1:0] != '0 || tag_order[baddr >> MIN_ORDER] == 0) begin
                g.status = ST_BAD_FREE;
                return g;
            end
            order = int'(tag_order[baddr >> MIN_ORDER]);
            tag_order[baddr >> MIN_ORDER] = '0;
            a = int'(baddr) & ~((1 << order) - 1);
            k = order;
            while (k < REGION_ORDER && free_bit[node_of(k, a ^ (1 << k))]) begin
                free_bit[node_of(k, a ^ (1 << k))] = 1'b0;
                a &= ~(1 << k);
                k++;
            end
            free_bit[node_of(k, a)] = 1'b1;
        end
        return g;
    endfunction

    // send one request, predicting its grant at the transfer
    task automatic send_request(logic cmd, logic [15:0] bytes, logic [11:0] baddr);
        grant_t g;
        req.valid <= 1'b1;
        req.command <= cmd;
        req.byte_count <= bytes;
        req.block_address <= baddr;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        g = predict_grant(cmd, bytes, baddr);
        grant_queue.push_back(g);
        if (cmd == REQ_ALLOC && g.status == ST_OK) live_blocks.push_back(g.addr);
        // random gap between bursts
        if ($urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        idle_sender();
        while (grant_queue.size() != 0) @(posedge clk);
    endtask

    task automatic send_alloc(logic [15:0] bytes);
        send_request(REQ_ALLOC, bytes, 12'($urandom));
    endtask

    task automatic send_free(logic [11:0] baddr);
        send_request(REQ_FREE, 16'($urandom), baddr);
    endtask

    task automatic free_random_live();
        int i;
        logic [11:0] a;
        i = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[i];
        live_blocks.delete(i);
        send_free(a);
    endtask

    // receiver stall pattern and long hold-off
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge clk) begin
        grant_t g;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (grant_queue.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, rsp.status);
                errors++;
            end else begin
                g = grant_queue.pop_front();
                if (rsp.status != g.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, g.status,
                             rsp.status);
                    errors++;
                end
                if (rsp.granted_address != g.addr) begin
                    $display("%0t: address expected %0h actual %0h", $time, g.addr,
                             rsp.granted_address);
                    errors++;
                end
                if (rsp.granted_order != g.order) begin
                    $display("%0t: order expected %0d actual %0d", $time, g.order,
                             rsp.granted_order);
                    errors++;
                end
            end
        end
    end

    task automatic test_edges();
        send_alloc(16'd0);
        send_alloc(16'd4);
        send_alloc(16'd5);
        send_alloc(16'd4092);
        send_alloc(16'd4093);
        send_alloc(16'hFFFF);
        send_free(12'h000);
        send_free(12'h000);
        send_free(12'h008);
        send_free(12'h003);
        send_free(12'hFFF);
        send_alloc(16'd4092);
        send_alloc(16'd0);
        send_free(12'h000);
        send_alloc(16'd1000);
        send_alloc(16'd2000);
        send_alloc(16'd100);
        drain();
        while (live_blocks.size() != 0) free_random_live();
        drain();
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 3) == 0) send_alloc(16'($urandom));
                else send_alloc(16'($urandom_range(0, 1 << $urandom_range(2, 11))));
            end else if (r < 88 && live_blocks.size() != 0) free_random_live();
            else if (r < 94) send_free(12'($urandom_range(0, 511) << MIN_ORDER));
            else send_free(12'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        test_random(40);
        drain();
    endtask

    task automatic test_exhaust();
        for (int i = 0; i < 520; i++) begin
            if (i % 3 == 0 && live_blocks.size() > 4) free_random_live();
            else send_alloc(16'd0);
        end
        while (live_blocks.size() != 0) free_random_live();
        drain();
    endtask

    initial begin
        req.valid = 1'b0;
        req.command = REQ_ALLOC;
        req.byte_count = '0;
        req.block_address = '0;
        rsp.ready = 1'b0;
        reset_allocator();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        stall_mode = 1;
        test_random(200);
        drain();
        test_backpressure();
        stall_mode = 2;
        test_random(150);
        drain();
        stall_mode = 0;
        test_exhaust();
        stall_mode = 1;
        test_random(60);
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && grant_queue.size() == 0)
            $display("buddy_block_allocator test passed");
        else
            $display("buddy_block_allocator test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("buddy_block_allocator test failed");
        $finish;
    end

endmodule
